### hw/rtl/lgs_pkg.sv
// Shared constants, register codes and the count store control bundle
// for the topic sampler. No dependencies.
package lgs_pkg;

  localparam int Q_FRAC      = 16;
  localparam int PRIOR_W     = 24;
  localparam int GTOT_W      = 15;
  localparam int TIU_W       = 7;
  localparam int WEIGHT_W    = 54;
  localparam int GTB_W       = PRIOR_W + GTOT_W;
  localparam int SUM_W       = 64;
  localparam int RND_W       = 32;
  localparam int TOPIC_OUT_W = 6;
  localparam int GIDX_W      = 14;
  localparam int SIDX_W      = 8;
  localparam int CIDX_W      = 6;
  localparam int REG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [WEIGHT_W-1:0] WEIGHT_CAP = '1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TOPICS = 2'd0,
    REG_ALPHA  = 2'd1,
    REG_BETA   = 2'd2,
    REG_GENES  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic rd;
    logic gene_we;
    logic samp_we;
    logic tot_we;
  } cnt_ctl_t;

endpackage

### hw/rtl/lgs_counts.sv
// Count store: gene-by-topic, sample-by-topic and per-topic totals memories,
// each with a registered read. Depends on lgs_pkg.
module lgs_counts #(
  parameter int MAX_TOPICS  = 64,
  parameter int MAX_GENES   = 16384,
  parameter int MAX_SAMPLES = 256,
  parameter int COUNT_BITS  = 32,
  localparam int GD  = MAX_GENES * MAX_TOPICS,
  localparam int SD  = MAX_SAMPLES * MAX_TOPICS,
  localparam int GAW = $clog2(GD),
  localparam int SAW = $clog2(SD),
  localparam int TW  = $clog2(MAX_TOPICS)
) (
  input  logic                  clk,
  input  lgs_pkg::cnt_ctl_t     ctl,
  input  logic [GAW-1:0]        gene_addr,
  input  logic [SAW-1:0]        samp_addr,
  input  logic [TW-1:0]         tot_addr,
  input  logic [COUNT_BITS-1:0] gene_wdata,
  input  logic [COUNT_BITS-1:0] samp_wdata,
  input  logic [COUNT_BITS-1:0] tot_wdata,
  output logic [COUNT_BITS-1:0] gene_rdata,
  output logic [COUNT_BITS-1:0] samp_rdata,
  output logic [COUNT_BITS-1:0] tot_rdata
);
  import lgs_pkg::*;

  logic [COUNT_BITS-1:0] gene_mem [GD];
  logic [COUNT_BITS-1:0] samp_mem [SD];
  logic [COUNT_BITS-1:0] tot_mem  [MAX_TOPICS];

  always_ff @(posedge clk) begin
    if (ctl.gene_we) begin
      gene_mem[gene_addr] <= gene_wdata;
    end
    if (ctl.rd) begin
      gene_rdata <= gene_mem[gene_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.samp_we) begin
      samp_mem[samp_addr] <= samp_wdata;
    end
    if (ctl.rd) begin
      samp_rdata <= samp_mem[samp_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tot_we) begin
      tot_mem[tot_addr] <= tot_wdata;
    end
    if (ctl.rd) begin
      tot_rdata <= tot_mem[tot_addr];
    end
  end

endmodule

### hw/rtl/lgs_weight.sv
// Topic weight unit: (gene+beta)*(sample+alpha)/(total+genes*beta) in Q.16,
// saturated; four partial products then one quotient bit a cycle. Depends on lgs_pkg.
module lgs_weight #(
  parameter int COUNT_BITS = 32,
  localparam int NW = COUNT_BITS + 17,
  localparam int HW = (NW + 1) / 2,
  localparam int PW = 2 * NW,
  localparam int DW = ((COUNT_BITS + 16 > lgs_pkg::GTB_W) ? COUNT_BITS + 16
                       : lgs_pkg::GTB_W) + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [COUNT_BITS-1:0]         gene_count,
  input  logic [COUNT_BITS-1:0]         samp_count,
  input  logic [COUNT_BITS-1:0]         tot_count,
  input  logic [lgs_pkg::PRIOR_W-1:0]   alpha,
  input  logic [lgs_pkg::PRIOR_W-1:0]   beta,
  input  logic [lgs_pkg::GTB_W-1:0]     gtb,
  output logic                          done,
  output logic [lgs_pkg::WEIGHT_W-1:0]  weight
);
  import lgs_pkg::*;

  typedef enum logic [3:0] {
    WS_IDLE = 4'b0001,
    WS_MUL  = 4'b0010,
    WS_CHK  = 4'b0100,
    WS_DIV  = 4'b1000
  } wstate_t;

  wstate_t              state;
  logic [5:0]           cnt;
  logic [NW-1:0]        gn;
  logic [NW-1:0]        sn;
  logic [DW-1:0]        dn;
  logic [2*HW-1:0]      pp;
  logic [1:0]           pk;
  logic [PW-1:0]        acc;
  logic [DW-1:0]        rem;
  logic [WEIGHT_W-1:0]  plo;
  logic [WEIGHT_W-1:0]  q;

  logic [HW-1:0]        a_sel;
  logic [HW-1:0]        b_sel;
  logic [PW-1:0]        pp_sh;
  logic [DW:0]          trial;
  logic                 ge;
  logic [DW-1:0]        rem_next;
  logic [WEIGHT_W-1:0]  q_next;
  logic                 ovf;

  always_comb begin
    a_sel = cnt[1] ? HW'(gn >> HW) : gn[HW-1:0];
    b_sel = cnt[0] ? HW'(sn >> HW) : sn[HW-1:0];
    unique case (pk)
      2'd0:    pp_sh = PW'(pp);
      2'd1:    pp_sh = PW'(pp) << HW;
      2'd2:    pp_sh = PW'(pp) << HW;
      default: pp_sh = PW'(pp) << (2 * HW);
    endcase
    trial    = {rem, plo[WEIGHT_W-1]};
    ge       = trial >= {1'b0, dn};
    rem_next = ge ? DW'(trial - {1'b0, dn}) : DW'(trial);
    q_next   = {q[WEIGHT_W-2:0], ge};
    ovf      = (acc >> WEIGHT_W) >= PW'(dn);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= WS_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        WS_IDLE: begin
          if (start) begin
            gn    <= NW'({gene_count, 16'b0}) + NW'(beta);
            sn    <= NW'({samp_count, 16'b0}) + NW'(alpha);
            dn    <= DW'({tot_count, 16'b0}) + DW'(gtb);
            acc   <= '0;
            cnt   <= '0;
            state <= WS_MUL;
          end
        end
        WS_MUL: begin
          if (cnt != 6'd4) begin
            pp <= (2*HW)'(a_sel) * (2*HW)'(b_sel);
            pk <= cnt[1:0];
          end
          if (cnt != 6'd0) begin
            acc <= acc + pp_sh;
          end
          if (cnt == 6'd4) begin
            state <= WS_CHK;
          end
          cnt <= cnt + 6'd1;
        end
        WS_CHK: begin
          if (ovf) begin
            weight <= WEIGHT_CAP;
            done   <= 1'b1;
            state  <= WS_IDLE;
          end else begin
            rem   <= DW'(acc >> WEIGHT_W);
            plo   <= acc[WEIGHT_W-1:0];
            q     <= '0;
            cnt   <= '0;
            state <= WS_DIV;
          end
        end
        WS_DIV: begin
          rem <= rem_next;
          plo <= plo << 1;
          q   <= q_next;
          cnt <= cnt + 6'd1;
          if (cnt == 6'(WEIGHT_W - 1)) begin
            weight <= q_next;
            done   <= 1'b1;
            state  <= WS_IDLE;
          end
        end
        default: state <= WS_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/lda_gibbs_topic_sampler_top.sv
// Topic sampler top level: sequencer, configuration registers and the
// cumulative weight memory. Depends on lgs_pkg, lgs_counts, lgs_weight.
//
// Usage: raise start with the token fields while busy is low; the request is
// taken at that edge and busy stays high until the result is out. The new
// topic appears on new_topic with done high for one cycle; done cannot be held.
// Configuration writes (write_enable, reg_index, write_data) take effect
// at the edge. The user must make them while busy is low; nothing enforces it.
// Operation: an initial assignment increments the counts of a topic drawn
// from random_word, after index reduction (none at default sizes). In a
// resample, each of the T topics in use runs one weight through the shared
// weight unit (product accumulation, an overflow check, then 54 quotient
// bits; a saturated weight skips the quotient bits), then the draw scans
// the cumulative weight memory entry by entry. One request at a time.
// Reset: synchronous on rst; configuration registers return to defaults and
// a clearing pass zeroes the count memories while busy is held high.
module lda_gibbs_topic_sampler_top #(
  parameter int MAX_TOPICS  = 64,
  parameter int MAX_GENES   = 16384,
  parameter int MAX_SAMPLES = 256,
  parameter int COUNT_BITS  = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             opcode,
  input  logic [lgs_pkg::GIDX_W-1:0]       gene_index,
  input  logic [lgs_pkg::SIDX_W-1:0]       sample_index,
  input  logic [lgs_pkg::CIDX_W-1:0]       current_topic,
  input  logic [lgs_pkg::RND_W-1:0]        random_word,
  output logic                             done,
  output logic [lgs_pkg::TOPIC_OUT_W-1:0]  new_topic,
  input  logic                             write_enable,
  input  logic [lgs_pkg::REG_IDX_W-1:0]    reg_index,
  input  logic [lgs_pkg::CFG_DATA_W-1:0]   write_data
);
  import lgs_pkg::*;

  localparam int GD      = MAX_GENES * MAX_TOPICS;
  localparam int SD      = MAX_SAMPLES * MAX_TOPICS;
  localparam int GAW     = $clog2(GD);
  localparam int SAW     = $clog2(SD);
  localparam int TW      = $clog2(MAX_TOPICS);
  localparam int TCW     = $clog2(MAX_TOPICS + 1);
  localparam int CLR_LEN = (GD > SD) ? GD : SD;
  localparam int CCW     = $clog2(CLR_LEN);

  typedef enum logic [13:0] {
    ST_CLEAR  = 14'b00000000000001,
    ST_IDLE   = 14'b00000000000010,
    ST_REDUCE = 14'b00000000000100,
    ST_DEC_RD = 14'b00000000001000,
    ST_DEC_WR = 14'b00000000010000,
    ST_W_RD   = 14'b00000000100000,
    ST_W_GO   = 14'b00000001000000,
    ST_W_CALC = 14'b00000010000000,
    ST_DRAW1  = 14'b00000100000000,
    ST_DRAW2  = 14'b00001000000000,
    ST_S_RD   = 14'b00010000000000,
    ST_S_CMP  = 14'b00100000000000,
    ST_INC_RD = 14'b01000000000000,
    ST_INC_WR = 14'b10000000000000
  } state_t;

  state_t                 state;
  logic [CCW-1:0]         clr;
  logic [TIU_W-1:0]       topics_in_use;
  logic [PRIOR_W-1:0]     alpha_q16;
  logic [PRIOR_W-1:0]     beta_q16;
  logic [GTOT_W-1:0]      gene_total;

  logic                   op;
  logic [GIDX_W-1:0]      g_red;
  logic [SIDX_W-1:0]      s_red;
  logic [CIDX_W-1:0]      cur;
  logic [RND_W-1:0]       rnd;
  logic [TCW-1:0]         t_eff;
  logic [PRIOR_W-1:0]     a_eff;
  logic [PRIOR_W-1:0]     b_eff;
  logic [GTB_W-1:0]       gtb;
  logic [GAW-1:0]         gbase;
  logic [SAW-1:0]         sbase;
  logic [TW-1:0]          ctopic;
  logic [SUM_W-1:0]       sum;
  logic [SUM_W-1:0]       ph;
  logic [SUM_W-1:0]       pl;
  logic [SUM_W-1:0]       r;
  logic [SUM_W-1:0]       cum_rd;
  logic [SUM_W-1:0]       cum_mem [MAX_TOPICS];

  logic [TCW-1:0]         t_in;
  logic [PRIOR_W-1:0]     a_in;
  logic [PRIOR_W-1:0]     b_in;
  logic [GTOT_W-1:0]      gt_in;
  logic [RND_W+TCW-1:0]   p0;
  logic [TW-1:0]          topic0;
  logic                   g_big;
  logic                   s_big;
  logic                   last_topic;
  logic [SUM_W-1:0]       sum_next;

  cnt_ctl_t               ctl;
  logic [GAW-1:0]         gene_addr;
  logic [SAW-1:0]         samp_addr;
  logic [TW-1:0]          tot_addr;
  logic [COUNT_BITS-1:0]  gene_wdata;
  logic [COUNT_BITS-1:0]  samp_wdata;
  logic [COUNT_BITS-1:0]  tot_wdata;
  logic [COUNT_BITS-1:0]  gene_rdata;
  logic [COUNT_BITS-1:0]  samp_rdata;
  logic [COUNT_BITS-1:0]  tot_rdata;

  logic                   wstart;
  logic                   wdone;
  logic [WEIGHT_W-1:0]    weight;

  function automatic logic [COUNT_BITS-1:0] sat_dec(input logic [COUNT_BITS-1:0] c);
    return (c == '0) ? c : c - 1'b1;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  always_comb begin
    if (topics_in_use == '0) begin
      t_in = TCW'(1);
    end else if (int'(topics_in_use) > MAX_TOPICS) begin
      t_in = TCW'(MAX_TOPICS);
    end else begin
      t_in = TCW'(topics_in_use);
    end
    a_in       = (alpha_q16 == '0) ? PRIOR_W'(1) : alpha_q16;
    b_in       = (beta_q16 == '0) ? PRIOR_W'(1) : beta_q16;
    gt_in      = (gene_total == '0) ? GTOT_W'(1) : gene_total;
    p0         = (RND_W+TCW)'(rnd) * (RND_W+TCW)'(t_eff);
    topic0     = TW'(p0 >> RND_W);
    g_big      = int'(g_red) >= MAX_GENES;
    s_big      = int'(s_red) >= MAX_SAMPLES;
    last_topic = (TCW'(ctopic) == t_eff - TCW'(1));
    sum_next   = sum + SUM_W'(weight);
  end

  always_comb begin
    ctl.rd      = (state == ST_DEC_RD) || (state == ST_W_RD) || (state == ST_INC_RD);
    ctl.gene_we = ((state == ST_CLEAR) && (int'(clr) < GD))
                  || (state == ST_DEC_WR) || (state == ST_INC_WR);
    ctl.samp_we = ((state == ST_CLEAR) && (int'(clr) < SD))
                  || (state == ST_DEC_WR) || (state == ST_INC_WR);
    ctl.tot_we  = ((state == ST_CLEAR) && (int'(clr) < MAX_TOPICS))
                  || (state == ST_DEC_WR) || (state == ST_INC_WR);
    if (state == ST_CLEAR) begin
      gene_addr  = GAW'(clr);
      samp_addr  = SAW'(clr);
      tot_addr   = TW'(clr);
      gene_wdata = '0;
      samp_wdata = '0;
      tot_wdata  = '0;
    end else begin
      gene_addr = gbase + GAW'(ctopic);
      samp_addr = sbase + SAW'(ctopic);
      tot_addr  = ctopic;
      if (state == ST_DEC_WR) begin
        gene_wdata = sat_dec(gene_rdata);
        samp_wdata = sat_dec(samp_rdata);
        tot_wdata  = sat_dec(tot_rdata);
      end else begin
        gene_wdata = sat_inc(gene_rdata);
        samp_wdata = sat_inc(samp_rdata);
        tot_wdata  = sat_inc(tot_rdata);
      end
    end
    wstart = (state == ST_W_GO);
    busy   = (state != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      topics_in_use <= TIU_W'(64);
      alpha_q16     <= PRIOR_W'(65536);
      beta_q16      <= PRIOR_W'(65536);
      gene_total    <= GTOT_W'(16384);
    end else if (write_enable) begin
      unique case (reg_idx_t'(reg_index))
        REG_TOPICS: topics_in_use <= write_data[TIU_W-1:0];
        REG_ALPHA:  alpha_q16     <= write_data[PRIOR_W-1:0];
        REG_BETA:   beta_q16      <= write_data[PRIOR_W-1:0];
        REG_GENES:  gene_total    <= write_data[GTOT_W-1:0];
        default:    gene_total    <= gene_total;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_W_CALC) && wdone) begin
      cum_mem[ctopic] <= sum_next;
    end
    if (state == ST_S_RD) begin
      cum_rd <= cum_mem[ctopic];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (int'(clr) == CLR_LEN - 1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            op    <= opcode;
            g_red <= gene_index;
            s_red <= sample_index;
            cur   <= current_topic;
            rnd   <= random_word;
            t_eff <= t_in;
            a_eff <= a_in;
            b_eff <= b_in;
            gtb   <= GTB_W'(gt_in) * GTB_W'(b_in);
            state <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (g_big) begin
            g_red <= g_red - GIDX_W'(MAX_GENES);
          end
          if (s_big) begin
            s_red <= s_red - SIDX_W'(MAX_SAMPLES);
          end
          if (!g_big && !s_big) begin
            gbase <= GAW'(int'(g_red) * MAX_TOPICS);
            sbase <= SAW'(int'(s_red) * MAX_TOPICS);
            sum   <= '0;
            if (!op) begin
              ctopic <= topic0;
              state  <= ST_INC_RD;
            end else if (int'(cur) < int'(t_eff)) begin
              ctopic <= TW'(cur);
              state  <= ST_DEC_RD;
            end else begin
              ctopic <= '0;
              state  <= ST_W_RD;
            end
          end
        end
        ST_DEC_RD: state <= ST_DEC_WR;
        ST_DEC_WR: begin
          ctopic <= '0;
          state  <= ST_W_RD;
        end
        ST_W_RD: state <= ST_W_GO;
        ST_W_GO: state <= ST_W_CALC;
        ST_W_CALC: begin
          if (wdone) begin
            sum <= sum_next;
            if (last_topic) begin
              state <= ST_DRAW1;
            end else begin
              ctopic <= ctopic + 1'b1;
              state  <= ST_W_RD;
            end
          end
        end
        ST_DRAW1: begin
          ph    <= SUM_W'(sum[63:32]) * SUM_W'(rnd);
          pl    <= SUM_W'(sum[31:0]) * SUM_W'(rnd);
          state <= ST_DRAW2;
        end
        ST_DRAW2: begin
          r      <= ph + SUM_W'(pl[63:32]);
          ctopic <= '0;
          state  <= ST_S_RD;
        end
        ST_S_RD: state <= ST_S_CMP;
        ST_S_CMP: begin
          if ((cum_rd >= r) || last_topic) begin
            state <= ST_INC_RD;
          end else begin
            ctopic <= ctopic + 1'b1;
            state  <= ST_S_RD;
          end
        end
        ST_INC_RD: state <= ST_INC_WR;
        ST_INC_WR: begin
          done      <= 1'b1;
          new_topic <= TOPIC_OUT_W'(ctopic);
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  lgs_counts #(
    .MAX_TOPICS  (MAX_TOPICS),
    .MAX_GENES   (MAX_GENES),
    .MAX_SAMPLES (MAX_SAMPLES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_counts (
    .clk        (clk),
    .ctl        (ctl),
    .gene_addr  (gene_addr),
    .samp_addr  (samp_addr),
    .tot_addr   (tot_addr),
    .gene_wdata (gene_wdata),
    .samp_wdata (samp_wdata),
    .tot_wdata  (tot_wdata),
    .gene_rdata (gene_rdata),
    .samp_rdata (samp_rdata),
    .tot_rdata  (tot_rdata)
  );

  lgs_weight #(
    .COUNT_BITS (COUNT_BITS)
  ) u_weight (
    .clk        (clk),
    .rst        (rst),
    .start      (wstart),
    .gene_count (gene_rdata),
    .samp_count (samp_rdata),
    .tot_count  (tot_rdata),
    .alpha      (a_eff),
    .beta       (b_eff),
    .gtb        (gtb),
    .done       (wdone),
    .weight     (weight)
  );

endmodule
